>>> rtl/positional_list_store_unit_defines.svh
// Assertion macros for the positional list store.
// Expects clk and rst_n in scope at the point of use.
`ifndef POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH

// Invariant checked on every clock edge outside reset.
`define PLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must be followed by a result in the next cycle.
`define PLS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/pls_pkg.sv
// Shared constants, codes and cell command type for the positional list store.
// No dependencies.
package pls_pkg;

  localparam int CAPACITY    = 16;
  localparam int OP_W        = 2;
  localparam int POS_W       = 5;
  localparam int DATA_W      = 32;
  localparam int ST_W        = 2;
  localparam int CNT_FIELD_W = 5;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_MODIFY = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              modify;
    logic [IDX_W-1:0]  tgt;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

>>> rtl/pls_in_if.sv
// Request channel of the positional list store: valid/ready plus one item.
// Depends on pls_pkg.
interface pls_in_if import pls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [OP_W-1:0]   operation;
  logic        [POS_W-1:0]  position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

>>> rtl/pls_out_if.sv
// Result channel of the positional list store: valid/ready plus one item.
// Depends on pls_pkg.
interface pls_out_if import pls_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic        [ST_W-1:0]        status;
  logic signed [DATA_W-1:0]      read_data;
  logic        [CNT_FIELD_W-1:0] element_count;
  logic                          is_empty;

  modport source (output valid, status, read_data, element_count, is_empty, input ready);
  modport sink   (input valid, status, read_data, element_count, is_empty, output ready);
endinterface

>>> rtl/pls_cell.sv
// One storage cell of the list chain: holds one element and shifts with its neighbours.
// Depends on pls_pkg.
module pls_cell import pls_pkg::*; (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]  idx,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              hit;
  logic              above;

  assign hit   = (idx == cmd.tgt);
  assign above = (idx > cmd.tgt);

  always_comb begin
    data_nxt = data_r;
    priority if (cmd.ins && hit) begin
      data_nxt = cmd.value;
    end else if (cmd.ins && above) begin
      data_nxt = left_data;
    end else if (cmd.rem && (hit || above)) begin
      data_nxt = right_data;
    end else if (cmd.modify && hit) begin
      data_nxt = cmd.value;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = hit ? data_r : '0;

endmodule

>>> rtl/positional_list_store_unit.sv
// Positional list store: top level with the cell chain, count and result register.
// Depends on pls_pkg, pls_in_if, pls_out_if, pls_cell and the defines header.
//
// Usage:
//   in_ch carries one request item: operation (read, modify, insert, remove),
//   1-based position and value. out_ch returns one result item per request:
//   status, read data, element count after the operation and an empty flag.
//   Items are accepted when valid and ready are both high.
//   The result is registered: a request accepted at one edge shows its result
//   from the next edge on. One item per cycle is sustained while out_ch.ready
//   stays high; every cell of the chain compares its index with the position
//   and shifts or loads in the same cycle, so the count register is the only loop.
//   A synchronous active-low reset empties the list and drops any pending
//   result; element contents are not cleared.
//   The result register parts the channels: in_ch.ready stays high while
//   out_ch is free or being taken this cycle, and drops while a result is
//   stalled, holding the request side until out_ch.ready returns.
`include "positional_list_store_unit_defines.svh"

module positional_list_store_unit import pls_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  pls_in_if.sink   in_ch,
  pls_out_if.source out_ch
);

  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_nxt;
  logic                   out_valid_r;
  status_t                st_r;
  status_t                st_nxt;
  logic [DATA_W-1:0]      rd_r;
  logic [DATA_W-1:0]      rd_nxt;
  logic [CNT_FIELD_W-1:0] cnt_out_r;
  logic                   empty_r;

  logic                   acc;
  op_t                    op;
  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       pos_m1;
  logic [CMP_W-1:0]       cnt_nxt_ext;
  logic                   pos_nz;
  logic                   in_list;
  logic                   ins_pos_ok;
  logic                   full;
  logic [DATA_W-1:0]      cell_or;
  cell_cmd_t              cmd;

  logic [DATA_W-1:0]      cell_data [CAPACITY];
  logic [DATA_W-1:0]      cell_rd   [CAPACITY];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign op          = op_t'(in_ch.operation);

  assign pos_ext     = CMP_W'(in_ch.position);
  assign cnt_ext     = CMP_W'(cnt_r);
  assign pos_m1      = pos_ext - CMP_W'(1);
  assign pos_nz      = (pos_ext != '0);
  assign in_list     = pos_nz && (pos_ext <= cnt_ext);
  assign ins_pos_ok  = pos_nz && (pos_ext <= (cnt_ext + CMP_W'(1)));
  assign full        = (cnt_r == CNT_W'(CAPACITY));
  assign cnt_nxt_ext = CMP_W'(cnt_nxt);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = cell_data[gi+1];
      end
      pls_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .idx        (IDX_W'(gi)),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (cell_data[gi]),
        .rd_data    (cell_rd[gi])
      );
    end
  endgenerate

  always_comb begin
    cell_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_or = cell_or | cell_rd[i];
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.tgt    = pos_m1[IDX_W-1:0];
    cmd.value  = in_ch.value;
    st_nxt     = ST_DONE;
    rd_nxt     = '0;
    cnt_nxt    = cnt_r;
    unique case (op)
      OP_READ: begin
        if (in_list) begin
          rd_nxt = cell_or;
        end else begin
          st_nxt = ST_BAD_POS;
          rd_nxt = '1;
        end
      end
      OP_MODIFY: begin
        if (in_list) begin
          cmd.modify = acc;
        end else begin
          st_nxt = ST_BAD_POS;
        end
      end
      OP_INSERT: begin
        if (!ins_pos_ok) begin
          st_nxt = ST_BAD_POS;
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          cmd.ins = acc;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (in_list) begin
          cmd.rem = acc;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          st_nxt = ST_BAD_POS;
        end
      end
      default: begin
        st_nxt = ST_BAD_POS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      st_r      <= st_nxt;
      rd_r      <= rd_nxt;
      cnt_out_r <= cnt_nxt_ext[CNT_FIELD_W-1:0];
      empty_r   <= (cnt_nxt == '0);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = st_r;
  assign out_ch.read_data     = rd_r;
  assign out_ch.element_count = cnt_out_r;
  assign out_ch.is_empty      = empty_r;

  `PLS_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(CAPACITY), "element count above capacity")
  `PLS_ASSERT(a_empty_match, out_valid_r |-> (empty_r == (cnt_r == '0)), "empty flag disagrees with count")
  `PLS_ASSERT_NEXT(a_ins_grow, acc && (op == OP_INSERT) && ins_pos_ok && !full, cnt_r == ($past(cnt_r) + CNT_W'(1)), "insert did not grow the list")
  `PLS_ASSERT_NEXT(a_rd_err, acc && (op == OP_READ) && !in_list, out_valid_r && (rd_r == '1) && (st_r == ST_BAD_POS), "bad read not reported")

endmodule
